// File: rtl/nlpr_pkg.sv
`default_nettype none

package nlpr_pkg;

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_GOOD     = 3'd1;
	localparam logic [2:0] EV_BAD_SUM  = 3'd2;
	localparam logic [2:0] EV_BAD_LEN  = 3'd3;
	localparam logic [2:0] EV_SPURIOUS = 3'd4;

	typedef struct packed {
		logic [4:0] data_lines;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       packet_end;
		logic [2:0] event_code;
		logic       nibble_timeout;
	} nlpr_result_t;

endpackage

`default_nettype wire

// File: rtl/nibble_link_packet_receiver.sv
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// in      | in_valid / in_ready  | status_lines
// out     | out_valid / out_ready| data_lines, byte_valid, byte_value, packet_end,
//         |                      | event_code, nibble_timeout, packets_done,
//         |                      | hard_errors, checksum_errors
// cfg     | cfg_write            | cfg_index, cfg_data
//
// One word in, one word out; a word is accepted every cycle when the output drains.
// Each word passes the input register, then the receive state update into the result register.
// The result register lets a new word enter while the previous result waits.
// Reset clears the receive state, counters and configuration to their defaults.
// An output stall backs up through the input register after one more word.

module nibble_link_packet_receiver
	import nlpr_pkg::*;
#(
	parameter int COUNT_WIDTH        = 16,
	parameter int RELEASE_WAIT_SHIFT = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [15:0]            cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             status_lines,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [4:0]                  data_lines,
	output logic                        byte_valid,
	output logic [7:0]                  byte_value,
	output logic                        packet_end,
	output logic [2:0]                  event_code,
	output logic                        nibble_timeout,
	output logic [COUNT_WIDTH-1:0]      packets_done,
	output logic [COUNT_WIDTH-1:0]      hard_errors,
	output logic [COUNT_WIDTH-1:0]      checksum_errors
);

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_MAX_LEN = 2'd1;
	localparam logic [1:0] REG_BUDGET  = 2'd2;

	logic         enable_q;
	logic [15:0]  max_len_q;
	logic [15:0]  budget_q;
	logic         valid_s1;
	logic [7:0]   status_s1;
	logic         out_valid_q;
	nlpr_result_t result_q;
	nlpr_result_t res_n;
	logic         advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			max_len_q <= 16'd1500;
			budget_q  <= 16'd1500;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_MAX_LEN: max_len_q <= cfg_data;
				REG_BUDGET:  budget_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			status_s1 <= status_lines;
		end
		if (advance) begin
			result_q <= res_n;
		end
	end

	nlpr_rx_fsm #(
		.COUNT_WIDTH        (COUNT_WIDTH),
		.RELEASE_WAIT_SHIFT (RELEASE_WAIT_SHIFT)
	) u_fsm (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.status           (status_s1),
		.enable           (enable_q),
		.max_len          (max_len_q),
		.budget           (budget_q),
		.result           (res_n),
		.good_count_q     (packets_done),
		.spurious_count_q (hard_errors),
		.bad_sum_count_q  (checksum_errors)
	);

	assign data_lines     = result_q.data_lines;
	assign byte_valid     = result_q.byte_valid;
	assign byte_value     = result_q.byte_value;
	assign packet_end     = result_q.packet_end;
	assign event_code     = result_q.event_code;
	assign nibble_timeout = result_q.nibble_timeout;

	a_no_byte_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.byte_valid && result_q.packet_end))
		else $error("payload byte and packet end in one word");

	a_event_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result_q.packet_end) |-> (result_q.event_code == EV_NONE))
		else $error("event code without packet end");

	a_spurious_count: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_n.event_code == EV_SPURIOUS)
		|=> (hard_errors == $past(hard_errors) + COUNT_WIDTH'(1)))
		else $error("spurious request not counted");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(packets_done) && $stable(checksum_errors)))
		else $error("counter moved without a word");

endmodule

`default_nettype wire

// File: rtl/nlpr_rx_fsm.sv
`default_nettype none

module nlpr_rx_fsm
	import nlpr_pkg::*;
#(
	parameter int COUNT_WIDTH        = 16,
	parameter int RELEASE_WAIT_SHIFT = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   step,
	input  wire logic [7:0]             status,
	input  wire logic                   enable,
	input  wire logic [15:0]            max_len,
	input  wire logic [15:0]            budget,
	output nlpr_result_t                result,
	output logic [COUNT_WIDTH-1:0]      good_count_q,
	output logic [COUNT_WIDTH-1:0]      spurious_count_q,
	output logic [COUNT_WIDTH-1:0]      bad_sum_count_q
);

	localparam int WAIT_W = 16 + RELEASE_WAIT_SHIFT;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_NIB_LOW  = 2'd1;
	localparam logic [1:0] PH_NIB_HIGH = 2'd2;
	localparam logic [1:0] PH_RELEASE  = 2'd3;

	localparam logic [1:0] ROLE_LEN_LO = 2'd0;
	localparam logic [1:0] ROLE_LEN_HI = 2'd1;
	localparam logic [1:0] ROLE_DATA   = 2'd2;
	localparam logic [1:0] ROLE_SUM    = 2'd3;

	localparam logic [7:0] STATUS_REQUEST = 8'hC7;
	localparam logic [7:0] STATUS_RELEASE = 8'h87;
	localparam logic [4:0] DATA_IDLE      = 5'h00;
	localparam logic [4:0] DATA_READY     = 5'h01;
	localparam logic [4:0] DATA_NIB_ACK   = 5'h10;

	logic [1:0]             phase_q, phase_n;
	logic                   prev_ack_q;
	logic [15:0]            poll_left_q, poll_left_n;
	logic [3:0]             low_nib_q, low_nib_n;
	logic [1:0]             role_q, role_n;
	logic [15:0]            plen_q, plen_n;
	logic [15:0]            bytes_left_q, bytes_left_n;
	logic [7:0]             sum_q, sum_n;
	logic [WAIT_W-1:0]      wait_left_q, wait_left_n;
	logic [4:0]             drive_q, drive_n;
	logic                   sum_ok_q, sum_ok_n;
	logic [COUNT_WIDTH-1:0] good_n, spur_n, bad_n;

	logic        ack, busy, byte_done;
	logic [7:0]  rx_byte;
	logic [15:0] budget_start, plen_full;
	logic        pend;
	logic [2:0]  ev;
	logic        tmo, bvalid;
	logic [7:0]  bvalue;

	assign ack          = status[6];
	assign busy         = status[7];
	assign budget_start = (budget == 16'd0) ? 16'd1 : budget;
	assign rx_byte      = {status[6:3], low_nib_q};
	assign plen_full    = {rx_byte, plen_q[7:0]};

	always_comb begin
		phase_n      = phase_q;
		poll_left_n  = poll_left_q;
		low_nib_n    = low_nib_q;
		role_n       = role_q;
		plen_n       = plen_q;
		bytes_left_n = bytes_left_q;
		sum_n        = sum_q;
		wait_left_n  = wait_left_q;
		drive_n      = drive_q;
		sum_ok_n     = sum_ok_q;
		good_n       = good_count_q;
		spur_n       = spurious_count_q;
		bad_n        = bad_sum_count_q;
		byte_done    = 1'b0;
		pend         = 1'b0;
		ev           = EV_NONE;
		tmo          = 1'b0;
		bvalid       = 1'b0;
		bvalue       = 8'd0;

		case (phase_q)
			PH_NIB_LOW: begin
				if (busy || poll_left_q <= 16'd1) begin
					if (!busy) begin
						poll_left_n = 16'd0;
					end
					low_nib_n = status[6:3];
					drive_n   = DATA_NIB_ACK;
					phase_n   = PH_NIB_HIGH;
				end else begin
					poll_left_n = poll_left_q - 16'd1;
				end
			end
			PH_NIB_HIGH: begin
				if (!busy || poll_left_q <= 16'd1) begin
					drive_n   = DATA_IDLE;
					tmo       = busy || (poll_left_q == 16'd0);
					byte_done = 1'b1;
				end else begin
					poll_left_n = poll_left_q - 16'd1;
				end
			end
			PH_RELEASE: begin
				if (status == STATUS_RELEASE || wait_left_q == '0) begin
					drive_n = DATA_IDLE;
					good_n  = good_count_q + COUNT_WIDTH'(1);
					pend    = 1'b1;
					ev      = sum_ok_q ? EV_GOOD : EV_BAD_SUM;
					phase_n = PH_IDLE;
				end else begin
					wait_left_n = wait_left_q - WAIT_W'(1);
				end
			end
			default: begin
				phase_n = PH_IDLE;
				drive_n = DATA_IDLE;
				if (enable && ack && !prev_ack_q) begin
					if (status != STATUS_REQUEST) begin
						spur_n = spurious_count_q + COUNT_WIDTH'(1);
						pend   = 1'b1;
						ev     = EV_SPURIOUS;
					end else begin
						drive_n     = DATA_READY;
						role_n      = ROLE_LEN_LO;
						sum_n       = 8'd0;
						poll_left_n = budget_start;
						phase_n     = PH_NIB_LOW;
					end
				end
			end
		endcase

		if (byte_done) begin
			poll_left_n = budget_start;
			phase_n     = PH_NIB_LOW;
			case (role_q)
				ROLE_LEN_LO: begin
					plen_n = {8'd0, rx_byte};
					role_n = ROLE_LEN_HI;
				end
				ROLE_LEN_HI: begin
					plen_n = plen_full;
					if (plen_full > max_len) begin
						pend    = 1'b1;
						ev      = EV_BAD_LEN;
						phase_n = PH_IDLE;
					end else begin
						wait_left_n  = WAIT_W'(plen_full) << RELEASE_WAIT_SHIFT;
						bytes_left_n = plen_full;
						role_n       = (plen_full == 16'd0) ? ROLE_SUM : ROLE_DATA;
					end
				end
				ROLE_DATA: begin
					bvalid       = 1'b1;
					bvalue       = rx_byte;
					sum_n        = sum_q + rx_byte;
					bytes_left_n = bytes_left_q - 16'd1;
					if (bytes_left_n == 16'd0) begin
						role_n = ROLE_SUM;
					end
				end
				default: begin
					sum_ok_n = (rx_byte == sum_q);
					if (rx_byte != sum_q) begin
						bad_n = bad_sum_count_q + COUNT_WIDTH'(1);
					end
					phase_n = PH_RELEASE;
				end
			endcase
		end
	end

	always_comb begin
		result.data_lines     = drive_n;
		result.byte_valid     = bvalid;
		result.byte_value     = bvalue;
		result.packet_end     = pend;
		result.event_code     = ev;
		result.nibble_timeout = tmo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			prev_ack_q       <= 1'b0;
			poll_left_q      <= 16'd0;
			low_nib_q        <= 4'd0;
			role_q           <= ROLE_LEN_LO;
			plen_q           <= 16'd0;
			bytes_left_q     <= 16'd0;
			sum_q            <= 8'd0;
			wait_left_q      <= '0;
			drive_q          <= DATA_IDLE;
			sum_ok_q         <= 1'b0;
			good_count_q     <= '0;
			spurious_count_q <= '0;
			bad_sum_count_q  <= '0;
		end else if (step) begin
			phase_q          <= phase_n;
			prev_ack_q       <= ack;
			poll_left_q      <= poll_left_n;
			low_nib_q        <= low_nib_n;
			role_q           <= role_n;
			plen_q           <= plen_n;
			bytes_left_q     <= bytes_left_n;
			sum_q            <= sum_n;
			wait_left_q      <= wait_left_n;
			drive_q          <= drive_n;
			sum_ok_q         <= sum_ok_n;
			good_count_q     <= good_n;
			spurious_count_q <= spur_n;
			bad_sum_count_q  <= bad_n;
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

import nlpr_pkg::*;

typedef enum logic [3:0] {RX_IDLE, RX_NIB_LOW, RX_NIB_HIGH, RX_RELEASE} rx_phase_e;
typedef enum logic [1:0] {BYTE_LEN_LO, BYTE_LEN_HI, BYTE_DATA, BYTE_SUM} byte_role_e;
typedef enum logic [1:0] {CFG_ENABLE, CFG_MAX_LEN, CFG_BUDGET, CFG_SPARE} cfg_reg_e;

localparam logic [7:0] STATUS_REQUEST   = 8'hC7;
localparam logic [7:0] STATUS_RELEASE   = 8'h87;
localparam logic [4:0] DRIVE_IDLE       = 5'h00;
localparam logic [4:0] DRIVE_READY      = 5'h01;
localparam logic [4:0] DRIVE_NIBBLE_ACK = 5'h10;
localparam int         RELEASE_SHIFT    = 5;

typedef struct packed {
	nlpr_result_t res;
	logic [15:0]  packets;
	logic [15:0]  hard;
	logic [15:0]  sums;
} rx_expect_t;

class rx_link_scoreboard;
	logic        rx_enable;
	logic [15:0] len_limit;
	logic [15:0] poll_budget;

	rx_phase_e   rx_phase;
	byte_role_e  role;
	logic        ack_seen;
	logic [15:0] polls_left;
	logic [3:0]  held_nib;
	logic [15:0] pkt_len;
	logic [15:0] bytes_to_go;
	logic [7:0]  sum_acc;
	logic [20:0] release_left;
	logic [4:0]  data_drive;
	logic [15:0] pkt_count;
	logic [15:0] spurious_count;
	logic [15:0] sum_err_count;
	logic        sum_ok;

	rx_expect_t  expected_outputs[$];
	int          mismatches;

	function new();
		rx_enable      = 1'b0;
		len_limit      = 16'd1500;
		poll_budget    = 16'd1500;
		rx_phase       = RX_IDLE;
		role           = BYTE_LEN_LO;
		ack_seen       = 1'b0;
		polls_left     = '0;
		held_nib       = '0;
		pkt_len        = '0;
		bytes_to_go    = '0;
		sum_acc        = '0;
		release_left   = '0;
		data_drive     = DRIVE_IDLE;
		pkt_count      = '0;
		spurious_count = '0;
		sum_err_count  = '0;
		sum_ok         = 1'b0;
		mismatches     = 0;
	endfunction

	function int start_budget();
		return (poll_budget == 16'd0) ? 1 : int'(poll_budget);
	endfunction

	function void set_register(cfg_reg_e idx, logic [15:0] value);
		case (idx)
			CFG_ENABLE:  rx_enable = value[0];
			CFG_MAX_LEN: len_limit = value;
			CFG_BUDGET:  poll_budget = value;
			default: ;
		endcase
	endfunction

	function void predict_status_word(logic [7:0] st);
		logic       ack;
		logic       busy;
		logic       done;
		logic       next_byte;
		logic [7:0] rx_byte;
		rx_expect_t e;
		ack     = st[6];
		busy    = st[7];
		done    = 1'b0;
		rx_byte = '0;
		e       = '0;
		case (rx_phase)
			RX_NIB_LOW: begin
				if (busy || polls_left <= 16'd1) begin
					if (!busy)
						polls_left = '0;
					held_nib   = st[6:3];
					data_drive = DRIVE_NIBBLE_ACK;
					rx_phase   = RX_NIB_HIGH;
				end else begin
					polls_left = polls_left - 16'd1;
				end
			end
			RX_NIB_HIGH: begin
				if (!busy || polls_left <= 16'd1) begin
					if (busy)
						polls_left = '0;
					rx_byte = {st[6:3], held_nib};
					data_drive = DRIVE_IDLE;
					e.res.nibble_timeout = (polls_left == 16'd0);
					done = 1'b1;
				end else begin
					polls_left = polls_left - 16'd1;
				end
			end
			RX_RELEASE: begin
				if (st == STATUS_RELEASE || release_left == 21'd0) begin
					data_drive = DRIVE_IDLE;
					pkt_count  = pkt_count + 16'd1;
					e.res.packet_end = 1'b1;
					e.res.event_code = sum_ok ? EV_GOOD : EV_BAD_SUM;
					rx_phase = RX_IDLE;
				end else begin
					release_left = release_left - 21'd1;
				end
			end
			default: begin
				rx_phase   = RX_IDLE;
				data_drive = DRIVE_IDLE;
				if (rx_enable && ack && !ack_seen) begin
					if (st != STATUS_REQUEST) begin
						spurious_count = spurious_count + 16'd1;
						e.res.packet_end = 1'b1;
						e.res.event_code = EV_SPURIOUS;
					end else begin
						data_drive = DRIVE_READY;
						role       = BYTE_LEN_LO;
						sum_acc    = '0;
						polls_left = 16'(start_budget());
						rx_phase   = RX_NIB_LOW;
					end
				end
			end
		endcase

		if (done) begin
			next_byte = 1'b1;
			case (role)
				BYTE_LEN_LO: begin
					pkt_len = {8'h00, rx_byte};
					role    = BYTE_LEN_HI;
				end
				BYTE_LEN_HI: begin
					pkt_len = {rx_byte, pkt_len[7:0]};
					if (pkt_len > len_limit) begin
						e.res.packet_end = 1'b1;
						e.res.event_code = EV_BAD_LEN;
						rx_phase  = RX_IDLE;
						next_byte = 1'b0;
					end else begin
						release_left = 21'(pkt_len) << RELEASE_SHIFT;
						bytes_to_go  = pkt_len;
						role = (pkt_len == 16'd0) ? BYTE_SUM : BYTE_DATA;
					end
				end
				BYTE_DATA: begin
					e.res.byte_valid = 1'b1;
					e.res.byte_value = rx_byte;
					sum_acc     = sum_acc + rx_byte;
					bytes_to_go = bytes_to_go - 16'd1;
					if (bytes_to_go == 16'd0)
						role = BYTE_SUM;
				end
				default: begin
					sum_ok = (rx_byte == sum_acc);
					if (!sum_ok)
						sum_err_count = sum_err_count + 16'd1;
					rx_phase  = RX_RELEASE;
					next_byte = 1'b0;
				end
			endcase
			if (next_byte) begin
				polls_left = 16'(start_budget());
				rx_phase   = RX_NIB_LOW;
			end
		end

		ack_seen = ack;
		e.res.data_lines = data_drive;
		e.packets = pkt_count;
		e.hard    = spurious_count;
		e.sums    = sum_err_count;
		expected_outputs.push_back(e);
	endfunction

	function void report(string msg);
		if (mismatches < 100)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endfunction

	function void compare_field(string what, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s: got 0x%0h, expected 0x%0h", what, got, want));
	endfunction

	function void check_output(rx_expect_t got);
		rx_expect_t want;
		if (expected_outputs.size() == 0) begin
			report("result word with no status word pending");
			return;
		end
		want = expected_outputs.pop_front();
		compare_field("data_lines", 16'(got.res.data_lines), 16'(want.res.data_lines));
		compare_field("byte_valid", 16'(got.res.byte_valid), 16'(want.res.byte_valid));
		compare_field("byte_value", 16'(got.res.byte_value), 16'(want.res.byte_value));
		compare_field("packet_end", 16'(got.res.packet_end), 16'(want.res.packet_end));
		compare_field("event_code", 16'(got.res.event_code), 16'(want.res.event_code));
		compare_field("nibble_timeout", 16'(got.res.nibble_timeout),
			16'(want.res.nibble_timeout));
		compare_field("packets_done", got.packets, want.packets);
		compare_field("hard_errors", got.hard, want.hard);
		compare_field("checksum_errors", got.sums, want.sums);
	endfunction
endclass

module tb_top;

	localparam int RANDOM_WORDS = 1850;
	localparam int STALL_LIMIT  = 4000;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        cfg_write       = 1'b0;
	logic [1:0]  cfg_index       = 2'd0;
	logic [15:0] cfg_data        = 16'd0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic [7:0]  status_lines    = 8'd0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic [4:0]  data_lines;
	logic        byte_valid;
	logic [7:0]  byte_value;
	logic        packet_end;
	logic [2:0]  event_code;
	logic        nibble_timeout;
	logic [15:0] packets_done;
	logic [15:0] hard_errors;
	logic [15:0] checksum_errors;

	rx_link_scoreboard sb = new();

	logic [7:0] status_fifo[$];
	int         counted_words = 0;
	int         burst_left = 0;
	int         gap_left = 0;
	int         hold_left = 0;
	int         mode_left = 0;
	int         rx_mode = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	bit         held_once = 1'b0;
	int         stall_cycles = 0;

	nibble_link_packet_receiver u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.status_lines    (status_lines),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.data_lines      (data_lines),
		.byte_valid      (byte_valid),
		.byte_value      (byte_value),
		.packet_end      (packet_end),
		.event_code      (event_code),
		.nibble_timeout  (nibble_timeout),
		.packets_done    (packets_done),
		.hard_errors     (hard_errors),
		.checksum_errors (checksum_errors)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin : drive_words
		logic       nxt_valid;
		logic [7:0] nxt_word;
		nxt_valid = in_valid;
		nxt_word  = status_lines;
		if (in_valid && in_ready)
			sb.predict_status_word(status_lines);
		if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				nxt_valid = 1'b0;
			end else if (status_fifo.size() != 0) begin
				nxt_valid = 1'b1;
				nxt_word  = status_fifo.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				nxt_valid = 1'b0;
			end
		end
		in_valid     <= nxt_valid;
		status_lines <= nxt_word;
	end

	always @(posedge clk) begin : drain_words
		logic       nxt_ready;
		rx_expect_t got;
		if (out_valid && out_ready) begin
			got.res.data_lines     = data_lines;
			got.res.byte_valid     = byte_valid;
			got.res.byte_value     = byte_value;
			got.res.packet_end     = packet_end;
			got.res.event_code     = event_code;
			got.res.nibble_timeout = nibble_timeout;
			got.packets            = packets_done;
			got.hard               = hard_errors;
			got.sums               = checksum_errors;
			sb.check_output(got);
		end
		nxt_ready = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			nxt_ready = 1'b0;
		end else if (!held_once && arst_n && status_fifo.size() > 8) begin
			held_once = 1'b1;
			hold_left = $urandom_range(60, 120);
			nxt_ready = 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode       = $urandom_range(0, 3);
				mode_left     = $urandom_range(16, 128);
				ready_pattern = 16'($urandom);
				if ($urandom_range(0, 15) == 0)
					hold_left = $urandom_range(20, 60);
			end
			mode_left--;
			case (rx_mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = ($urandom_range(0, 3) != 0);
				2: begin
					nxt_ready     = ready_pattern[0];
					ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
				end
				default: nxt_ready = ($urandom_range(0, 1) != 0);
			endcase
		end
		out_ready <= nxt_ready;
	end

	initial begin : watchdog
		wait (arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic push_word(logic [7:0] w);
		status_fifo.push_back(w);
		if (sb.rx_enable)
			counted_words++;
	endtask

	task automatic wait_drained();
		while (status_fifo.size() != 0 || in_valid || sb.expected_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_e idx, logic [15:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_register(idx, value);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// drive the block back to idle with zero nibbles and a release word
	task automatic settle_receiver();
		wait_drained();
		while (sb.rx_phase != RX_IDLE) begin
			case (sb.rx_phase)
				RX_NIB_LOW:  push_word(8'h80);
				RX_NIB_HIGH: push_word(8'h00);
				default:     push_word(STATUS_RELEASE);
			endcase
			wait_drained();
		end
	endtask

	task automatic add_byte(logic [7:0] b, bit noisy);
		int maxp;
		int k;
		int m;
		maxp = (sb.start_budget() > 4) ? 3 : sb.start_budget() - 1;
		if (noisy) begin
			k = $urandom_range(0, 4);
			m = $urandom_range(0, 4);
		end else begin
			k = $urandom_range(0, maxp);
			m = $urandom_range(0, maxp - k);
		end
		repeat (k) push_word({1'b0, 7'($urandom)});
		push_word({1'b1, b[3:0], 3'($urandom)});
		repeat (m) push_word({1'b1, 7'($urandom)});
		push_word({1'b0, b[7:4], 3'($urandom)});
	endtask

	function automatic logic [7:0] non_release_word();
		logic [7:0] w;
		w = 8'($urandom);
		return (w == STATUS_RELEASE) ? 8'h00 : w;
	endfunction

	task automatic add_packet(int len, bit bad_sum, bit noisy);
		logic [7:0] sum;
		logic [7:0] b;
		int         wait_ticks;
		int         r;
		push_word({1'($urandom), 1'b0, 6'($urandom)});
		push_word(STATUS_REQUEST);
		add_byte(len[7:0], noisy);
		add_byte(len[15:8], noisy);
		if (len > int'(sb.len_limit))
			return;
		sum = '0;
		for (int i = 0; i < len; i++) begin
			b   = 8'($urandom);
			sum = sum + b;
			add_byte(b, noisy);
		end
		add_byte(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum, noisy);
		wait_ticks = len << RELEASE_SHIFT;
		if (len <= 2 && $urandom_range(0, 3) == 0) begin
			// run the release wait out
			repeat (wait_ticks + 1) push_word(non_release_word());
		end else begin
			r = $urandom_range(0, (wait_ticks < 6) ? wait_ticks : 6);
			repeat (r) push_word(non_release_word());
			push_word(STATUS_RELEASE);
		end
	endtask

	function automatic int pick_len();
		int lim;
		lim = (sb.len_limit > 16'd24) ? 24 : int'(sb.len_limit);
		if ($urandom_range(0, 7) != 0 && lim > 4)
			lim = 4;
		return $urandom_range(0, lim);
	endfunction

	initial begin : main_seq
		int          phase_idx;
		int          n_act;
		int          sel;
		int          lo_bad;
		int          len;
		bit          safe;
		bit          en;
		logic [15:0] mx;
		logic [15:0] bd;
		logic [7:0]  w;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ack rising while disabled
		push_word(8'h00);
		push_word(8'hFF);
		wait_drained();
		write_register(CFG_ENABLE, 16'd1);
		push_word(8'h00);
		push_word(8'h40);
		push_word(8'h3F);
		push_word(STATUS_REQUEST);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		// disable mid-packet; the packet still completes
		wait_drained();
		write_register(CFG_ENABLE, 16'd0);
		add_byte(8'h00, 1'b0);
		push_word(STATUS_RELEASE);
		wait_drained();
		write_register(CFG_ENABLE, 16'd1);
		write_register(CFG_MAX_LEN, 16'd0);
		push_word(8'h00);
		push_word(STATUS_REQUEST);
		add_byte(8'h01, 1'b0);
		add_byte(8'h00, 1'b0);
		wait_drained();
		write_register(CFG_BUDGET, 16'd1);
		push_word(8'h00);
		push_word(STATUS_REQUEST);
		push_word(8'h78);
		push_word(8'hFF);

		for (phase_idx = 0; counted_words < RANDOM_WORDS; phase_idx++) begin
			settle_receiver();
			case (phase_idx)
				0: begin
					en = 1'b1;
					mx = 16'hFFFF;
					bd = 16'hFFFF;
				end
				1: begin
					en = 1'b1;
					mx = 16'd0;
					bd = 16'd0;
				end
				2: begin
					en = 1'b1;
					mx = 16'd8;
					bd = 16'd1;
				end
				default: begin
					en = ($urandom_range(0, 7) != 0);
					case ($urandom_range(0, 6))
						0: bd = 16'd0;
						1: bd = 16'd1;
						2: bd = 16'd2;
						3: bd = 16'd3;
						4: bd = 16'($urandom_range(4, 12));
						5: bd = 16'd1500;
						default: bd = 16'hFFFF;
					endcase
					if ($urandom_range(0, 3) == 0) begin
						case ($urandom_range(0, 2))
							0: mx = 16'hFFFF;
							1: mx = 16'd1500;
							default: mx = 16'($urandom_range(256, 65535));
						endcase
					end else begin
						case ($urandom_range(0, 3))
							0: mx = 16'd0;
							1: mx = 16'd1;
							2: mx = 16'($urandom_range(2, 12));
							default: mx = 16'($urandom_range(13, 64));
						endcase
					end
				end
			endcase
			// keep garbage lengths short where framing can slip
			safe = (mx > 16'd64);
			write_register(CFG_ENABLE, {15'd0, en});
			write_register(CFG_MAX_LEN, mx);
			write_register(CFG_BUDGET, bd);
			if (phase_idx == 1)
				write_register(CFG_SPARE, 16'($urandom));

			n_act = en ? $urandom_range(6, 14) : 3;
			repeat (n_act) begin
				sel = $urandom_range(0, 15);
				if (sel < 10 || (safe && sel >= 14)) begin
					add_packet(pick_len(), ($urandom_range(0, 3) == 0), 1'b0);
				end else if (sel < 12) begin
					if (sb.len_limit != 16'hFFFF) begin
						lo_bad = int'(sb.len_limit) + 1;
						len = ($urandom_range(0, 3) == 0) ? 65535 :
							$urandom_range(lo_bad, (lo_bad + 20 > 65535) ? 65535 : lo_bad + 20);
						add_packet(len, 1'b0, 1'b0);
					end else begin
						add_packet(pick_len(), 1'b0, 1'b0);
					end
				end else if (sel == 12) begin
					push_word({1'($urandom), 1'b0, 6'($urandom)});
					w = 8'($urandom) | 8'h40;
					push_word((w == STATUS_REQUEST) ? 8'h40 : w);
				end else if (sel == 13) begin
					repeat ($urandom_range(1, 6)) begin
						w = 8'($urandom);
						push_word((safe && w == STATUS_REQUEST) ? 8'h00 : w);
					end
				end else if (sel == 14) begin
					add_packet(pick_len(), ($urandom_range(0, 3) == 0), 1'b1);
				end else begin
					// stop after the low length byte, or both length bytes, with a short length
					push_word({1'($urandom), 1'b0, 6'($urandom)});
					push_word(STATUS_REQUEST);
					add_byte(8'($urandom_range(0, 4)), 1'b0);
					if ($urandom_range(0, 1) == 0)
						add_byte(8'h00, 1'b0);
				end
			end
		end
		settle_receiver();

		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
